### rtl/hde_pkg.sv
// Shared types and constants of the hyperexponential evaluator.
// No dependencies; imported by every rtl module of the block but hde_checker.
package hde_pkg;

    // Input field and register widths
    localparam int unsigned XW   = 32;          // Q16.16 point
    localparam int unsigned WW   = 17;          // Q1.16 weight
    localparam int unsigned RW   = 24;          // Q8.16 rate
    localparam int unsigned WRW  = WW + RW;     // weight * rate
    localparam int unsigned EW   = 33;          // exp(-p) in Q0.32, may equal 1.0
    localparam int unsigned SW   = 27;          // survival sum, Q3.24
    localparam int unsigned MW   = 27;          // numerator magnitude
    localparam int unsigned VW   = 32;          // result, signed Q8.24
    localparam int unsigned CIW  = 3;           // config index
    localparam int unsigned CDW  = 24;          // config data

    // Exponential unit
    localparam int unsigned HORNER_TERMS = 12;
    localparam int unsigned EXP_LAT      = 4 + 3 * HORNER_TERMS + 1;
    localparam logic [31:0] LOG2E_FRAC   = 32'h7154_7653;
    localparam logic [31:0] LN2_Q32      = 32'hB172_17F8;
    localparam logic [EW-1:0] ONE_Q32    = 33'h1_0000_0000;
    localparam logic [24:0] ONE_Q24      = 25'h100_0000;

    // Divider: quotient bits retired per stage
    localparam int unsigned QW          = 33;
    localparam int unsigned DIV_BITS    = 3;
    localparam int unsigned DIV_STAGES  = QW / DIV_BITS;

    typedef enum logic [1:0] {
        OP_DENS,
        OP_DIST,
        OP_CDENS,
        OP_CDIST
    } t_op;

    typedef enum logic [CIW-1:0] {
        CFG_PHASE_COUNT,
        CFG_WEIGHT_0,
        CFG_WEIGHT_1,
        CFG_WEIGHT_2,
        CFG_RATE_0,
        CFG_RATE_1,
        CFG_RATE_2
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_ctl;

    // Request from the combine stage into the divider
    typedef struct packed {
        logic          valid;
        logic          bypass;
        logic          fault;
        logic          neg;
        logic [MW-1:0] mag;
        logic [SW-1:0] div;
        logic [VW-1:0] direct;
    } t_div_req;

endpackage

### rtl/hde_exp.sv
// Pipelined exp(-rate*x) in Q0.32: range reduction, 12-term Horner series, final shift.
// Depends on hde_pkg. One beat per cycle while i_en is high.
module hde_exp (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [hde_pkg::RW-1:0]   i_rate,
    input  logic [hde_pkg::XW-1:0]   i_xs,
    output logic [hde_pkg::EW-1:0]   o_e
);
    import hde_pkg::*;

    typedef struct packed {
        logic [31:0] y;
        logic [5:0]  n;
        logic        cut;
    } t_side;

    logic [55:0] n_p;
    logic [55:0] r_p;
    logic [63:0] r_prod;
    logic [36:0] r_phc;
    logic [37:0] r_p2;
    logic        r_cut2;
    logic [37:0] n_q;
    logic [31:0] r_g;
    logic [5:0]  r_n3;
    logic        r_cut3;
    logic [63:0] n_y;
    t_side       r_s4;
    logic [EW-1:0] w_h [HORNER_TERMS+1];
    t_side         w_s [HORNER_TERMS+1];
    logic [5:0]  w_nn;
    logic [33:0] n_rnd;
    logic [33:0] n_sh;
    logic [EW-1:0] r_e;

    // p = rate * x
    assign n_p = i_rate * i_xs;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    // scale by log2(e): high and low halves separately
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= r_p[31:0] * LOG2E_FRAC;
            r_phc  <= r_p[36:32] * LOG2E_FRAC;
            r_p2   <= r_p[37:0];
            r_cut2 <= |r_p[55:37];
        end
    end

    // q = integer part n and fraction g
    assign n_q = r_p2 + 38'(r_phc) + 38'(r_prod[63:32]);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g    <= n_q[31:0];
            r_n3   <= n_q[37:32];
            r_cut3 <= r_cut2;
        end
    end

    // y = g * ln2
    assign n_y = r_g * LN2_Q32;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4.y   <= n_y[63:32];
            r_s4.n   <= r_n3;
            r_s4.cut <= r_cut3;
        end
    end

    assign w_h[0] = ONE_Q32;
    assign w_s[0] = r_s4;

    // Horner steps, k from HORNER_TERMS down to 1, three stages each
    for (genvar j = 0; j < HORNER_TERMS; j++) begin : g_horner
        localparam int unsigned K = HORNER_TERMS - j;
        localparam logic [63:0] RECIP = (64'd1 << 32) / K;

        logic [64:0]   n_mh;
        logic [31:0]   r_m;
        t_side         r_sa;
        logic [31:0]   r_q0;
        logic [31:0]   r_mb;
        t_side         r_sb;
        logic [35:0]   n_qk;
        logic [35:0]   n_rem;
        logic [31:0]   n_qc;
        logic [EW-1:0] r_h;
        t_side         r_sc;

        // m = y * h
        assign n_mh = w_s[j].y * w_h[j];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m  <= n_mh[63:32];
                r_sa <= w_s[j];
            end
        end

        // estimate of m / k by reciprocal
        if (K == 1) begin : g_unit
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q0 <= r_m;
                end
            end
        end else begin : g_recip
            logic [63:0] n_mr;
            assign n_mr = r_m * RECIP[31:0];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q0 <= n_mr[63:32];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mb <= r_m;
                r_sb <= r_sa;
            end
        end

        // estimate is low by at most one: single correction, then h = 1 - m/k
        assign n_qk  = 36'(r_q0) * 36'(K);
        assign n_rem = 36'(r_mb) - n_qk;
        assign n_qc  = r_q0 + 32'(n_rem >= 36'(K));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_h  <= ONE_Q32 - {1'b0, n_qc};
                r_sc <= r_sb;
            end
        end

        assign w_h[j+1] = r_h;
        assign w_s[j+1] = r_sc;
    end

    // scale by 2^-n with rounding; zero when p overflows or n >= 40
    assign w_nn  = w_s[HORNER_TERMS].n;
    assign n_rnd = {1'b0, w_h[HORNER_TERMS]} + (34'd1 << (w_nn - 6'd1));
    assign n_sh  = n_rnd >> w_nn;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_s[HORNER_TERMS].cut || w_nn >= 6'd40) begin
                r_e <= '0;
            end else if (w_nn == 6'd0) begin
                r_e <= w_h[HORNER_TERMS];
            end else begin
                r_e <= n_sh[EW-1:0];
            end
        end
    end

    assign o_e = r_e;

endmodule

### rtl/hde_combine.sv
// Mixes the phase exponentials into density, survival and distribution,
// then forms the divider request. Depends on hde_pkg. Four stages.
module hde_combine #(
    parameter int unsigned MAX_PHASES = 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  hde_pkg::t_ctl             i_ctl,
    input  logic [MAX_PHASES-1:0]     i_use,
    input  logic [hde_pkg::WW-1:0]    i_weight [MAX_PHASES],
    input  logic [hde_pkg::WRW-1:0]   i_wr     [MAX_PHASES],
    input  logic [hde_pkg::EW-1:0]    i_ea     [MAX_PHASES],
    input  logic [hde_pkg::EW-1:0]    i_eb     [MAX_PHASES],
    output hde_pkg::t_div_req         o_req
);
    import hde_pkg::*;

    logic [57:0] r_a  [MAX_PHASES];
    logic [56:0] r_b  [MAX_PHASES];
    logic [49:0] r_wa [MAX_PHASES];
    logic [49:0] r_wb [MAX_PHASES];
    logic [34:0] r_td [MAX_PHASES];
    logic [26:0] r_ta [MAX_PHASES];
    logic [26:0] r_tb [MAX_PHASES];
    logic [MAX_PHASES-1:0] r_use1;
    t_ctl        r_ctl1, r_ctl2, r_ctl3;
    logic [36:0] n_dens;
    logic [SW-1:0] n_sa, n_sb;
    logic [24:0] r_dens;
    logic [SW-1:0] r_sa, r_sb;
    logic signed [27:0] r_fa;
    logic signed [27:0] n_diff;
    t_div_req    n_req, r_req;

    // control travels with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_use1 <= i_use;
        end
    end

    for (genvar i = 0; i < MAX_PHASES; i++) begin : g_phase
        logic [57:0] n_b2;
        logic [58:0] n_t;
        logic [50:0] n_ra, n_rb;

        // products per phase
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[i]  <= i_wr[i] * i_ea[i][32:16];
                r_b[i]  <= i_wr[i] * i_ea[i][15:0];
                r_wa[i] <= i_weight[i] * i_ea[i];
                r_wb[i] <= i_weight[i] * i_eb[i];
            end
        end

        // rounded terms, zero for unused phases
        assign n_b2 = 58'(r_b[i]) + 58'h80_0000_0000;
        assign n_t  = 59'(r_a[i]) + 59'(n_b2 >> 16);
        assign n_ra = 51'(r_wa[i]) + 51'h80_0000;
        assign n_rb = 51'(r_wb[i]) + 51'h80_0000;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_td[i] <= r_use1[i] ? n_t[58:24]  : '0;
                r_ta[i] <= r_use1[i] ? n_ra[50:24] : '0;
                r_tb[i] <= r_use1[i] ? n_rb[50:24] : '0;
            end
        end
    end

    // sums over phases
    always_comb begin
        n_dens = '0;
        n_sa   = '0;
        n_sb   = '0;
        for (int i = 0; i < MAX_PHASES; i++) begin
            n_dens = n_dens + 37'(r_td[i]);
            n_sa   = n_sa + r_ta[i];
            n_sb   = n_sb + r_tb[i];
        end
    end

    // density above 1.0 forces zero; F = 1 - S
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dens <= (n_dens > 37'(ONE_Q24)) ? '0 : n_dens[24:0];
            r_sa   <= n_sa;
            r_sb   <= n_sb;
            r_fa   <= 28'(ONE_Q24) - 28'(n_sa);
        end
    end

    // F(x+t) - F(t) = S(t) - S(x+t)
    assign n_diff = $signed({1'b0, r_sb}) - $signed({1'b0, r_sa});

    always_comb begin
        n_req        = '0;
        n_req.valid  = r_ctl3.valid;
        n_req.div    = r_sb;
        case (r_ctl3.op)
            OP_DENS: begin
                n_req.bypass = 1'b1;
                n_req.direct = 32'(r_dens);
            end
            OP_DIST: begin
                n_req.bypass = 1'b1;
                n_req.direct = {{4{r_fa[27]}}, r_fa};
            end
            OP_CDENS: begin
                n_req.mag = 27'(r_dens);
            end
            default: begin
                n_req.neg = n_diff[27];
                n_req.mag = n_diff[27] ? 27'(-n_diff) : 27'(n_diff);
            end
        endcase
        n_req.fault = !n_req.bypass && (r_sb == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req <= '0;
        end else if (i_en) begin
            r_req <= n_req;
        end
    end

    assign o_req = r_req;

endmodule

### rtl/hde_div.sv
// Pipelined restoring divider for the conditioned results, with rounding and
// saturation; the last stage is the output register. Depends on hde_pkg.
module hde_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  hde_pkg::t_div_req       i_req,
    output logic                    o_valid,
    output logic [hde_pkg::VW-1:0]  o_value,
    output logic                    o_fault
);
    import hde_pkg::*;

    typedef struct packed {
        logic          valid;
        logic          bypass;
        logic          fault;
        logic          neg;
        logic          ovf;
        logic [SW-1:0] div;
        logic [SW:0]   rem;
        logic [QW-1:0] q;
        logic [QW-1:0] dlo;
        logic [VW-1:0] direct;
    } t_dstage;

    logic [51:0] n_d;
    t_dstage     n_prep, r_prep;
    t_dstage     w_st [DIV_STAGES+1];
    t_dstage     w_last;
    logic        n_big;
    logic [VW-1:0] n_qs;
    logic [VW-1:0] n_val;
    logic        r_valid;
    logic [VW-1:0] r_value;
    logic        r_fault;

    // dividend = mag * 2^24 + div/2; quotient of 2^33 or more saturates anyway
    assign n_d = {1'b0, i_req.mag, 24'b0} + 52'(i_req.div >> 1);
    always_comb begin
        n_prep        = '0;
        n_prep.valid  = i_req.valid;
        n_prep.bypass = i_req.bypass;
        n_prep.fault  = i_req.fault;
        n_prep.neg    = i_req.neg;
        n_prep.div    = i_req.div;
        n_prep.direct = i_req.direct;
        n_prep.ovf    = 27'(n_d[51:33]) >= i_req.div;
        n_prep.rem    = 28'(n_d[51:33]);
        n_prep.dlo    = n_d[QW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep <= '0;
        end else if (i_en) begin
            r_prep <= n_prep;
        end
    end

    assign w_st[0] = r_prep;

    // DIV_BITS quotient bits per stage
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_step
        t_dstage n_nxt, r_st;

        always_comb begin
            n_nxt = w_st[s];
            for (int b = 0; b < DIV_BITS; b++) begin
                n_nxt.rem = {n_nxt.rem[SW-1:0], n_nxt.dlo[QW-1]};
                n_nxt.dlo = n_nxt.dlo << 1;
                if (n_nxt.rem >= {1'b0, n_nxt.div}) begin
                    n_nxt.rem = n_nxt.rem - {1'b0, n_nxt.div};
                    n_nxt.q   = {n_nxt.q[QW-2:0], 1'b1};
                end else begin
                    n_nxt.q   = {n_nxt.q[QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st <= '0;
            end else if (i_en) begin
                r_st <= n_nxt;
            end
        end

        assign w_st[s+1] = r_st;
    end

    assign w_last = w_st[DIV_STAGES];

    // saturate magnitude at 2^31, apply sign
    assign n_big = w_last.ovf || w_last.fault || (w_last.q > 33'h0_8000_0000);
    assign n_qs  = n_big ? 32'h8000_0000 : w_last.q[VW-1:0];
    always_comb begin
        if (w_last.bypass) begin
            n_val = w_last.direct;
        end else if (w_last.neg) begin
            n_val = -n_qs;
        end else if (n_qs == 32'h8000_0000) begin
            n_val = 32'h7FFF_FFFF;
        end else begin
            n_val = n_qs;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= n_val;
            r_fault <= w_last.fault;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_fault = r_fault;

endmodule

### rtl/hyperexp_distribution_eval_core.sv
// Top level of the hyperexponential density/distribution evaluator.
// Depends on hde_pkg, hde_exp, hde_combine, hde_div.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------
//  input    | i_valid / o_stall        | i_operation, i_x_value, i_elapsed_t
//  result   | o_valid / i_stall        | o_value, o_divide_fault
//  config   | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One beat accepted per cycle while o_stall is low; a beat passes the input
// stage, the exp units with their 12-step Horner chain, the combine stages
// and the divider stages. The whole pipeline advances unless a result sits in
// the output register with i_stall high; o_stall is exactly that condition.
// Synchronous active-low reset clears valid bits and loads register defaults.
module hyperexp_distribution_eval_core #(
    parameter int unsigned MAX_PHASES = 3
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_operation,
    input  logic [hde_pkg::XW-1:0]   i_x_value,
    input  logic [hde_pkg::XW-1:0]   i_elapsed_t,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [hde_pkg::VW-1:0]   o_value,
    output logic                     o_divide_fault,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [hde_pkg::CIW-1:0]  i_cfg_index,
    input  logic [hde_pkg::CDW-1:0]  i_cfg_data
);
    import hde_pkg::*;

    logic                  w_en;
    logic [1:0]            r_phase_count;
    logic [WW-1:0]         r_weight [MAX_PHASES];
    logic [RW-1:0]         r_rate   [MAX_PHASES];
    logic [WRW-1:0]        r_wr     [MAX_PHASES];
    logic [MAX_PHASES-1:0] w_use;
    logic [XW:0]           n_xt;
    t_ctl                  r_ctl0;
    logic [XW-1:0]         r_xa;
    logic [XW-1:0]         r_t;
    t_ctl                  r_dly [EXP_LAT];
    logic [EW-1:0]         w_ea [MAX_PHASES];
    logic [EW-1:0]         w_eb [MAX_PHASES];
    t_div_req              w_req;

    // global advance
    assign w_en        = !o_valid || !i_stall;
    assign o_stall     = !w_en;
    assign o_cfg_ready = 1'b1;

    // phase count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_count <= 2'd1;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PHASE_COUNT: r_phase_count <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // per-phase weight and rate registers
    for (genvar i = 0; i < MAX_PHASES; i++) begin : g_cfg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_weight[i] <= (i == 0) ? 17'h1_0000 : 17'h0;
                r_rate[i]   <= 24'h01_0000;
            end else if (i_cfg_valid) begin
                if (i_cfg_index == CIW'(CFG_WEIGHT_0) + CIW'(i)) begin
                    r_weight[i] <= i_cfg_data[WW-1:0];
                end
                if (i_cfg_index == CIW'(CFG_RATE_0) + CIW'(i)) begin
                    r_rate[i] <= i_cfg_data[RW-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_wr[i] <= r_weight[i] * r_rate[i];
        end

        assign w_use[i] = r_phase_count > 2'(i);
    end

    // input stage: pick the evaluation point, x+t saturated for conditioned ops
    assign n_xt = {1'b0, i_x_value} + {1'b0, i_elapsed_t};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else if (w_en) begin
            r_ctl0.valid <= i_valid;
            r_ctl0.op    <= t_op'(i_operation);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xa <= i_operation[1] ? (n_xt[XW] ? '1 : n_xt[XW-1:0]) : i_x_value;
            r_t  <= i_elapsed_t;
        end
    end

    // control alongside the exp units
    for (genvar d = 0; d < EXP_LAT; d++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dly[d] <= '0;
            end else if (w_en) begin
                r_dly[d] <= (d == 0) ? r_ctl0 : r_dly[(d == 0) ? 0 : d - 1];
            end
        end
    end

    // exp units: evaluation point and conditioning time, one pair per phase
    for (genvar i = 0; i < MAX_PHASES; i++) begin : g_exp
        hde_exp u_exp_a (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rate (r_rate[i]),
            .i_xs   (r_xa),
            .o_e    (w_ea[i])
        );

        hde_exp u_exp_b (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rate (r_rate[i]),
            .i_xs   (r_t),
            .o_e    (w_eb[i])
        );
    end

    hde_combine #(
        .MAX_PHASES (MAX_PHASES)
    ) u_combine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_ctl    (r_dly[EXP_LAT-1]),
        .i_use    (w_use),
        .i_weight (r_weight),
        .i_wr     (r_wr),
        .i_ea     (w_ea),
        .i_eb     (w_eb),
        .o_req    (w_req)
    );

    hde_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_req   (w_req),
        .o_valid (o_valid),
        .o_value (o_value),
        .o_fault (o_divide_fault)
    );

endmodule

### rtl/hde_checker.sv
// Port-level checks of the evaluator's result channel and stall logic,
// bound to hyperexp_distribution_eval_core. Depends on nothing else.
module hde_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_value,
    input logic        o_divide_fault
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value) && $stable(o_divide_fault))
        else $error("result beat changed while stalled");

    // input back-pressure only when the output register is blocked
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("o_stall does not follow output back-pressure");

    // a zero divisor always gives a saturated value
    a_fault_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_fault |-> (o_value == 32'h7FFF_FFFF || o_value == 32'h8000_0000))
        else $error("divide fault without saturated value");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind hyperexp_distribution_eval_core hde_checker u_hde_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_value        (o_value),
    .o_divide_fault (o_divide_fault)
);
